/* rtl/text_console_writer_top_macros.svh */
// Assertion macros of the console writer checker.
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds across reset.
`define TCW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tcw_pkg.sv */
// Shared types and constants of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int FUNC_W = 3;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int CUR_W  = 11;
  localparam int IN_W   = 32;
  localparam int OUT_W  = 32;

  localparam logic [FUNC_W-1:0] FUNC_PUT_CUR = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUT_POS = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET_CUR = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd4;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] BLANK_ATTR   = 8'h07;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic cnt_zero;
    logic cnt_last_row;
    logic cnt_inc;
    logic blank_wr;
    logic scr_rd;
    logic scr_wr;
    logic cap_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_read_hit;
    logic need_scroll;
    logic blank_last;
    logic scr_last;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/tcw_ctrl.sv */
// Controller state machine of the text console writer.
`timescale 1ns / 1ps
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_BLANK,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        cmd.blank_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.blank_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        priority if (sts.need_scroll) begin
          cmd.cnt_zero = 1'b1;
          state_nxt    = ST_SCR_RD;
        end else if (sts.is_clear) begin
          cmd.cnt_zero = 1'b1;
          state_nxt    = ST_BLANK;
        end else if (sts.is_read_hit) begin
          state_nxt = ST_RDWAIT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RDWAIT: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_SCR_RD: begin
        cmd.scr_rd = 1'b1;
        state_nxt  = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd.scr_wr = 1'b1;
        if (sts.scr_last) begin
          cmd.cnt_last_row = 1'b1;
          state_nxt        = ST_BLANK;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = ST_SCR_RD;
        end
      end
      ST_BLANK: begin
        cmd.blank_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.blank_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/tcw_datapath.sv */
// Datapath of the text console writer: cell memory, cursor, sweep counter, result.
`timescale 1ns / 1ps
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic [FUNC_W-1:0] in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  input  cmd_t              cmd,
  output sts_t              sts
);

  localparam int CELLS = COLS * ROWS;
  localparam int LAST  = COLS * (ROWS - 1);
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);

  logic [2*CHAR_W-1:0] mem [CELLS];
  logic [2*CHAR_W-1:0] rdata_r;

  logic [FUNC_W-1:0] itm_func_r;
  logic [ROW_W-1:0]  itm_row_r;
  logic [COL_W-1:0]  itm_col_r;
  logic [CHAR_W-1:0] itm_char_r;
  logic [CHAR_W-1:0] itm_attr_r;

  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [AW-1:0] cnt_r;

  logic              res_ign_r, res_ign_nxt;
  logic              res_scr_r, res_scr_nxt;
  logic [CHAR_W-1:0] res_char_r;
  logic [CHAR_W-1:0] res_attr_r;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [2*CHAR_W-1:0] wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;

  logic          in_range;
  logic [AW-1:0] item_addr;
  logic [AW-1:0] cur_lin;
  logic          is_newline;
  logic          col_is_last;
  logic          row_is_last;

  assign in_range    = (32'(itm_row_r) < ROWS) && (32'(itm_col_r) < COLS);
  assign item_addr   = AW'(itm_row_r) * AW'(COLS) + AW'(itm_col_r);
  assign cur_lin     = AW'(cur_row_r) * AW'(COLS) + AW'(cur_col_r);
  assign is_newline  = (itm_char_r == NEWLINE_CHAR);
  assign col_is_last = (cur_col_r == CW'(COLS - 1));
  assign row_is_last = (cur_row_r == RW'(ROWS - 1));

  assign sts.is_clear    = (itm_func_r == FUNC_CLEAR);
  assign sts.is_read_hit = (itm_func_r == FUNC_READ) && in_range;
  assign sts.need_scroll = (itm_func_r == FUNC_PUT_CUR) && row_is_last
                           && (is_newline || col_is_last);
  assign sts.blank_last  = (cnt_r == AW'(CELLS - 1));
  assign sts.scr_last    = (cnt_r == AW'(LAST - 1));
  assign sts.out_busy    = out_valid_r && !out_tready;

  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = cnt_r;
    wr_data     = {BLANK_ATTR, BLANK_CHAR};
    rd_en       = 1'b0;
    rd_addr     = item_addr;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    res_ign_nxt = res_ign_r;
    res_scr_nxt = res_scr_r;
    if (cmd.exec) begin
      res_ign_nxt = 1'b0;
      res_scr_nxt = 1'b0;
      unique case (itm_func_r)
        FUNC_PUT_CUR: begin
          if (!is_newline) begin
            wr_en   = 1'b1;
            wr_addr = cur_lin;
            wr_data = {itm_attr_r, itm_char_r};
          end
          if (is_newline || col_is_last) begin
            cur_col_nxt = '0;
            if (row_is_last) begin
              // scroll leaves the cursor at the bottom row start
              res_scr_nxt = 1'b1;
            end else begin
              cur_row_nxt = RW'(cur_row_r + 1'b1);
            end
          end else begin
            cur_col_nxt = CW'(cur_col_r + 1'b1);
          end
        end
        FUNC_PUT_POS: begin
          if (in_range) begin
            wr_en   = 1'b1;
            wr_addr = item_addr;
            wr_data = {itm_attr_r, itm_char_r};
          end else begin
            res_ign_nxt = 1'b1;
          end
        end
        FUNC_SET_CUR: begin
          if (in_range) begin
            cur_row_nxt = RW'(itm_row_r);
            cur_col_nxt = CW'(itm_col_r);
          end else begin
            res_ign_nxt = 1'b1;
          end
        end
        FUNC_CLEAR: begin
          cur_row_nxt = '0;
          cur_col_nxt = '0;
        end
        FUNC_READ: begin
          if (in_range) rd_en = 1'b1;
          else          res_ign_nxt = 1'b1;
        end
        default: res_ign_nxt = 1'b1;
      endcase
    end
    if (cmd.blank_wr) wr_en = 1'b1;
    if (cmd.scr_rd) begin
      rd_en   = 1'b1;
      rd_addr = AW'(cnt_r + AW'(COLS));
    end
    if (cmd.scr_wr) begin
      wr_en   = 1'b1;
      wr_data = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      itm_func_r <= in_tuser;
      itm_row_r  <= in_tdata[4:0];
      itm_col_r  <= in_tdata[11:5];
      itm_char_r <= in_tdata[19:12];
      itm_attr_r <= in_tdata[27:20];
    end
    res_ign_r <= res_ign_nxt;
    res_scr_r <= res_scr_nxt;
    if (cmd.exec) begin
      res_char_r <= '0;
      res_attr_r <= '0;
    end else if (cmd.cap_rd) begin
      res_char_r <= rdata_r[CHAR_W-1:0];
      res_attr_r <= rdata_r[2*CHAR_W-1:CHAR_W];
    end
    if (cmd.out_load) begin
      out_data_r <= {3'b000, res_scr_r, res_ign_r, res_attr_r, res_char_r,
                     CUR_W'(cur_lin)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      priority if (cmd.cnt_zero)     cnt_r <= '0;
      else if (cmd.cnt_last_row)     cnt_r <= AW'(LAST);
      else if (cmd.cnt_inc)          cnt_r <= AW'(cnt_r + 1'b1);
      else                           cnt_r <= cnt_r;
      if (cmd.out_load)     out_valid_r <= 1'b1;
      else if (out_tready)  out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/text_console_writer_top.sv */
// Top level of the text console writer.
// Each operation runs EXEC, then RDWAIT for a read that hits, then DONE, which loads
// the output register once it is free; a new operation is taken only back in IDLE.
// A scroll reads and writes each moved cell, then blanks the bottom row of COLS cells.
// A clear does one blank write per cell through the single write port.
// Reset: synchronous, active low; a clearing pass over all cells follows, in_tready low.
`timescale 1ns / 1ps
module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // row[4:0], col[11:5], char_code[19:12], color[27:20]
  input  logic [FUNC_W-1:0] in_tuser,   // func[2:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // cursor_now[10:0], read_char[18:11],
                                        // read_color[26:19], ignored[27], scrolled[28]
);

  cmd_t cmd;
  sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

/* rtl/tcw_checker.sv */
// Port-level checker of the text console writer and its bind.
`timescale 1ns / 1ps
`include "text_console_writer_top_macros.svh"
module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam int  CELLS = COLS * ROWS;
  localparam int  LAST  = COLS * (ROWS - 1);
  localparam bit  WIDE  = (CELLS >= (1 << CUR_W));

  logic             out_stall;
  logic [CUR_W-1:0] cur_now;
  logic             ign_f;
  logic             scr_f;
  logic             cur_ok;
  logic             scr_ok;

  assign out_stall = out_tvalid && !out_tready;
  assign cur_now   = out_tdata[CUR_W-1:0];
  assign ign_f     = out_tdata[27];
  assign scr_f     = out_tdata[28];
  assign cur_ok    = WIDE || (cur_now < CUR_W'(CELLS));
  assign scr_ok    = WIDE || (cur_now == CUR_W'(LAST));

  `TCW_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata), "result changed")
  `TCW_ASSERT(a_cursor_range, out_tvalid |-> cur_ok, "cursor beyond screen")
  `TCW_ASSERT(a_flags_excl, out_tvalid |-> !(ign_f && scr_f), "ignored and scrolled both set")
  `TCW_ASSERT(a_scroll_cursor, out_tvalid && scr_f |-> scr_ok, "scroll cursor off row start")
  `TCW_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_tvalid && !in_tready, "activity after reset")

endmodule

bind text_console_writer_top tcw_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcw_checker (.*);

/* sim/tb_text_console_writer_top.sv */
// Self-checking testbench for the text console writer: directed table, then random operations.
`timescale 1ns / 1ps
module tb_text_console_writer_top;
  import tcw_pkg::*;

  localparam int COLS           = 80;
  localparam int ROWS           = 25;
  localparam int NUM_CELLS      = COLS * ROWS;
  localparam int LAST_ROW_START = COLS * (ROWS - 1);
  localparam int STALL_LIMIT    = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 20;

  // Codes the block leaves unused
  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] attr;
  } console_op_t;

  typedef struct {
    logic [CUR_W-1:0]  cursor_now;
    logic [CHAR_W-1:0] read_char;
    logic [CHAR_W-1:0] read_color;
    logic              ignored;
    logic              scrolled;
  } console_res_t;

  typedef struct {
    console_op_t  op;
    bit           known;
    console_res_t res;
  } dir_row_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;
  logic [FUNC_W-1:0] in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  // Shadow copy of the console
  logic [CHAR_W-1:0] shadow_char [NUM_CELLS];
  logic [CHAR_W-1:0] shadow_attr [NUM_CELLS];
  int unsigned       shadow_cursor;

  console_res_t      pending_results[$];
  dir_row_t          dir_tab[$];
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;
  int                hold_left   = 0;
  int                n_sent      = 0;
  int                n_fail      = 0;
  int                quiet_cycles = 0;

  text_console_writer_top #(.COLS(COLS), .ROWS(ROWS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // row[4:0], col[11:5], char_code[19:12], color[27:20]
    .in_tuser   (in_tuser),    // func[2:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)    // cursor_now[10:0], read_char[18:11], read_color[26:19],
                               // ignored[27], scrolled[28]
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void blank_screen();
    for (int i = 0; i < NUM_CELLS; i++) begin
      shadow_char[i] = BLANK_CHAR;
      shadow_attr[i] = BLANK_ATTR;
    end
  endfunction

  function automatic console_res_t predict_console(console_op_t op);
    console_res_t r;
    int unsigned  pos;
    int unsigned  addr;
    bit           hit;
    r    = '{default: '0};
    hit  = (op.row < ROWS) && (op.col < COLS);
    addr = op.row * COLS + op.col;
    case (op.func)
      FUNC_PUT_CUR: begin
        pos = shadow_cursor;
        if (pos >= NUM_CELLS) pos = 0;
        if (op.ch == NEWLINE_CHAR) begin
          pos = COLS * (pos / COLS + 1);
        end else begin
          shadow_char[pos] = op.ch;
          shadow_attr[pos] = op.attr;
          pos++;
        end
        // Move every row up one, attributes with characters
        if (pos >= NUM_CELLS) begin
          for (int i = 0; i < LAST_ROW_START; i++) begin
            shadow_char[i] = shadow_char[i + COLS];
            shadow_attr[i] = shadow_attr[i + COLS];
          end
          for (int i = LAST_ROW_START; i < NUM_CELLS; i++) begin
            shadow_char[i] = BLANK_CHAR;
            shadow_attr[i] = BLANK_ATTR;
          end
          pos        = LAST_ROW_START;
          r.scrolled = 1'b1;
        end
        shadow_cursor = pos;
      end
      FUNC_PUT_POS: begin
        if (hit) begin
          shadow_char[addr] = op.ch;
          shadow_attr[addr] = op.attr;
        end else begin
          r.ignored = 1'b1;
        end
      end
      FUNC_SET_CUR: begin
        if (hit) shadow_cursor = addr;
        else r.ignored = 1'b1;
      end
      FUNC_CLEAR: begin
        blank_screen();
        shadow_cursor = 0;
      end
      FUNC_READ: begin
        if (hit) begin
          r.read_char  = shadow_char[addr];
          r.read_color = shadow_attr[addr];
        end else begin
          r.ignored = 1'b1;
        end
      end
      default: r.ignored = 1'b1;
    endcase
    r.cursor_now = shadow_cursor[CUR_W-1:0];
    return r;
  endfunction

  function automatic console_op_t mk_op(logic [FUNC_W-1:0] func, int row, int col,
                                        int ch, int attr);
    console_op_t op;
    op.func = func;
    op.row  = row[ROW_W-1:0];
    op.col  = col[COL_W-1:0];
    op.ch   = ch[CHAR_W-1:0];
    op.attr = attr[CHAR_W-1:0];
    return op;
  endfunction

  function automatic dir_row_t dir_row(logic [FUNC_W-1:0] func, int row, int col, int ch,
                                       int attr, bit known, int cur = 0, int rc = 0,
                                       int ra = 0, bit ign = 0, bit scr = 0);
    dir_row_t d;
    d.op               = mk_op(func, row, col, ch, attr);
    d.known            = known;
    d.res.cursor_now   = cur[CUR_W-1:0];
    d.res.read_char    = rc[CHAR_W-1:0];
    d.res.read_color   = ra[CHAR_W-1:0];
    d.res.ignored      = ign;
    d.res.scrolled     = scr;
    return d;
  endfunction

  task automatic send_op(console_op_t op, bit known = 1'b0, console_res_t typed = '{default: '0});
    console_res_t exp_res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, op.attr, op.ch, op.col, op.row};
    in_tuser  <= op.func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_res = predict_console(op);
    if (known) exp_res = typed;
    pending_results.push_back(exp_res);
    n_sent++;
  endtask

  // Lower valid and hold until every outstanding result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int count);
    int target;
    int pick;
    int len;
    int row;
    target = n_sent + count;
    while (n_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        // Text run: place the cursor, type a line, look at the result
        row = ($urandom_range(9) < 3) ? $urandom_range(ROWS - 1, ROWS - 3)
                                      : $urandom_range(ROWS - 1);
        send_op(mk_op(FUNC_SET_CUR, row, $urandom_range(COLS - 1), $urandom_range(255),
                      $urandom_range(255)));
        len = $urandom_range(16, 3);
        for (int i = 0; i < len; i++) begin
          send_op(mk_op(FUNC_PUT_CUR, $urandom_range(31), $urandom_range(127),
                        ($urandom_range(7) == 0) ? int'(NEWLINE_CHAR) : $urandom_range(255),
                        $urandom_range(255)));
        end
        send_op(mk_op(FUNC_READ, shadow_cursor / COLS, $urandom_range(COLS - 1),
                      $urandom_range(255), $urandom_range(255)));
        if ($urandom_range(1)) begin
          send_op(mk_op(FUNC_READ, (shadow_cursor / COLS + ROWS - 1) % ROWS,
                        $urandom_range(COLS - 1), $urandom_range(255), $urandom_range(255)));
        end
      end else if (pick < 60) begin
        if ($urandom_range(1))
          send_op(mk_op(FUNC_PUT_POS, $urandom_range(ROWS - 1), $urandom_range(COLS - 1),
                        $urandom_range(255), $urandom_range(255)));
        else
          send_op(mk_op(FUNC_PUT_POS, $urandom_range(31), $urandom_range(127),
                        $urandom_range(255), $urandom_range(255)));
      end else if (pick < 80) begin
        if ($urandom_range(3) != 0)
          send_op(mk_op(FUNC_READ, $urandom_range(ROWS - 1), $urandom_range(COLS - 1),
                        $urandom_range(255), $urandom_range(255)));
        else
          send_op(mk_op(FUNC_READ, $urandom_range(31), $urandom_range(127),
                        $urandom_range(255), $urandom_range(255)));
      end else if (pick < 88) begin
        send_op(mk_op(FUNC_SET_CUR, $urandom_range(31), $urandom_range(127),
                      $urandom_range(255), $urandom_range(255)));
      end else if (pick < 93) begin
        send_op(mk_op(FUNC_PUT_CUR, $urandom_range(31), $urandom_range(127),
                      $urandom_range(255), $urandom_range(255)));
      end else if (pick < 95) begin
        case ($urandom_range(2))
          0:       send_op(mk_op(FUNC_SPARE_A, $urandom_range(31), $urandom_range(127),
                                 $urandom_range(255), $urandom_range(255)));
          1:       send_op(mk_op(FUNC_SPARE_B, $urandom_range(31), $urandom_range(127),
                                 $urandom_range(255), $urandom_range(255)));
          default: send_op(mk_op(FUNC_SPARE_C, $urandom_range(31), $urandom_range(127),
                                 $urandom_range(255), $urandom_range(255)));
        endcase
      end else if (pick < 97) begin
        send_op(mk_op(FUNC_CLEAR, $urandom_range(31), $urandom_range(127),
                      $urandom_range(255), $urandom_range(255)));
      end else begin
        send_op(mk_op(FUNC_PUT_CUR, $urandom_range(31), $urandom_range(127),
                      NEWLINE_CHAR, $urandom_range(255)));
      end
    end
  endtask

  // Receiver: random back-pressure plus an optional long hold
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result transaction with the oldest expected one
  always @(posedge clk) begin
    console_res_t exp_res;
    console_res_t got;
    if (out_tvalid && out_tready) begin
      got.cursor_now = out_tdata[10:0];
      got.read_char  = out_tdata[18:11];
      got.read_color = out_tdata[26:19];
      got.ignored    = out_tdata[27];
      got.scrolled   = out_tdata[28];
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction, tdata %h", out_tdata);
        n_fail++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got.cursor_now !== exp_res.cursor_now) begin
          $error("cursor_now expected %0d got %0d", exp_res.cursor_now, got.cursor_now);
          n_fail++;
        end
        if (got.read_char !== exp_res.read_char) begin
          $error("read_char expected %h got %h", exp_res.read_char, got.read_char);
          n_fail++;
        end
        if (got.read_color !== exp_res.read_color) begin
          $error("read_color expected %h got %h", exp_res.read_color, got.read_color);
          n_fail++;
        end
        if (got.ignored !== exp_res.ignored) begin
          $error("ignored expected %0b got %0b", exp_res.ignored, got.ignored);
          n_fail++;
        end
        if (got.scrolled !== exp_res.scrolled) begin
          $error("scrolled expected %0b got %0b", exp_res.scrolled, got.scrolled);
          n_fail++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_text_console_writer_top NOT OK");
      $finish;
    end
  end

  initial begin
    blank_screen();
    shadow_cursor = 0;

    dir_tab.push_back(dir_row(FUNC_READ,     0,   0,    0,    0, 1, 0, 8'h20, 8'h07));
    dir_tab.push_back(dir_row(FUNC_READ,    24,  79,    0,    0, 1, 0, 8'h20, 8'h07));
    dir_tab.push_back(dir_row(FUNC_READ,    31, 127, 8'hFF, 8'hFF, 1, 0, 0, 0, 1));
    dir_tab.push_back(dir_row(FUNC_PUT_POS,  0,   0, 8'hFF, 8'hFF, 0));
    dir_tab.push_back(dir_row(FUNC_READ,     0,   0,    0,    0, 0));
    dir_tab.push_back(dir_row(FUNC_PUT_POS, 25,   0, 8'h55, 8'hAA, 1, 0, 0, 0, 1));
    dir_tab.push_back(dir_row(FUNC_PUT_POS,  0,  80, 8'h55, 8'hAA, 1, 0, 0, 0, 1));
    dir_tab.push_back(dir_row(FUNC_PUT_POS, 24,  79, 8'h80, 8'h80, 0));
    dir_tab.push_back(dir_row(FUNC_SET_CUR, 24,  79,    0,    0, 1, NUM_CELLS - 1));
    // Write to the last cell scrolls the screen
    dir_tab.push_back(dir_row(FUNC_PUT_CUR,  0,   0, 8'h41, 8'h1E, 1, LAST_ROW_START,
                              0, 0, 0, 1));
    dir_tab.push_back(dir_row(FUNC_READ,    23,  79,    0,    0, 0));
    dir_tab.push_back(dir_row(FUNC_READ,    24,  79,    0,    0, 1, LAST_ROW_START,
                              8'h20, 8'h07));
    // Newline on the bottom row scrolls too
    dir_tab.push_back(dir_row(FUNC_SET_CUR, 24,   5,    0,    0, 0));
    dir_tab.push_back(dir_row(FUNC_PUT_CUR,  0,   0, NEWLINE_CHAR, 8'h33, 0));
    dir_tab.push_back(dir_row(FUNC_SET_CUR, 31, 127,    0,    0, 1, LAST_ROW_START,
                              0, 0, 1));
    dir_tab.push_back(dir_row(FUNC_SET_CUR, 25,  79,    0,    0, 1, LAST_ROW_START,
                              0, 0, 1));
    dir_tab.push_back(dir_row(FUNC_SPARE_A,  3,   4, 8'h11, 8'h22, 1, LAST_ROW_START,
                              0, 0, 1));
    dir_tab.push_back(dir_row(FUNC_SPARE_B, 31, 127, 8'hFF, 8'hFF, 1, LAST_ROW_START,
                              0, 0, 1));
    dir_tab.push_back(dir_row(FUNC_SPARE_C,  0,   0,    0,    0, 1, LAST_ROW_START,
                              0, 0, 1));
    dir_tab.push_back(dir_row(FUNC_SET_CUR,  3,  10,    0,    0, 0));
    dir_tab.push_back(dir_row(FUNC_PUT_CUR,  0,   0,    0,    0, 0));
    dir_tab.push_back(dir_row(FUNC_PUT_CUR,  0,   0, NEWLINE_CHAR, 8'h00, 0));
    dir_tab.push_back(dir_row(FUNC_CLEAR,    0,   0,    0,    0, 1, 0));
    dir_tab.push_back(dir_row(FUNC_READ,     0,   0,    0,    0, 1, 0, 8'h20, 8'h07));
    dir_tab.push_back(dir_row(FUNC_PUT_CUR,  0,   0, 8'hFF, 8'hFF, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 8;
    rx_idle_pct = 65;
    foreach (dir_tab[i]) send_op(dir_tab[i].op, dir_tab[i].known, dir_tab[i].res);
    run_random(100);
    // Long receiver hold while items keep coming, so the input backs up
    hold_left = HOLD_CYCLES;
    run_random(110);

    tx_idle_pct = 65;
    rx_idle_pct = 8;
    run_random(120);
    drain_results();
    run_random(110);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(230);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("tb_text_console_writer_top OK");
    end else begin
      $display("tb_text_console_writer_top NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_writer_top.sv
rtl/tcw_checker.sv
sim/tb_text_console_writer_top.sv
